// ===== hw/rtl/raw10_pixel_pack_unpack_assert.svh =====
// Assertion macros shared by the RAW10 pack/unpack RTL files.
`ifndef RAW10_PIXEL_PACK_UNPACK_ASSERT_SVH
`define RAW10_PIXEL_PACK_UNPACK_ASSERT_SVH

// Both macros expect i_clk and i_rst_n to exist in the using module.
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/rpp_pkg.sv =====
// Types and constants shared by the RAW10 pack/unpack modules.
package rpp_pkg;

    localparam int VALUE_W = 10;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [PHASE_W-1:0] GROUP_LEN = 3'd4;
    localparam logic [1:0]         LOW_MASK  = 2'b11;
    localparam logic [BYTE_W-1:0]  BYTE_MASK = 8'hff;

    // Register indexes on the configuration port.
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_BIT_ORDER = 1'b1;

    typedef enum logic {
        DIR_UNPACK = 1'b0,
        DIR_PACK   = 1'b1
    } t_direction;

    typedef enum logic {
        ORDER_PLAIN = 1'b0,
        ORDER_MIPI  = 1'b1
    } t_bit_order;

    typedef struct packed {
        t_direction direction;
        t_bit_order bit_order;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] in_value;
        logic               frame_start;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] out_value;
        logic               last_of_run;
    } t_out_item;

    // Up to four results made by one input item; last_idx is the count minus one.
    typedef struct packed {
        logic [1:0]              last_idx;
        logic [3:0][VALUE_W-1:0] value;
    } t_job;

endpackage

// ===== hw/rtl/rpp_front.sv =====
// Front end: tracks the group phase, holds group values and builds result jobs.
`include "raw10_pixel_pack_unpack_assert.svh"

module rpp_front import rpp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_job     o_job
);

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [BYTE_W-1:0]  r_held [4];

    logic [PHASE_W-1:0] phase_in;
    logic [PHASE_W-1:0] phase_eff;
    logic               hold_we;
    logic [BYTE_W-1:0]  hold_data;
    logic [3:0][VALUE_W-1:0] unpack_pix;
    logic [BYTE_W-1:0]  packed_lows;

    // Frame start restarts the group; out-of-range phases fold back to zero.
    always_comb begin
        phase_in = i_item.frame_start ? '0 : r_phase;
        if (i_cfg.direction == DIR_UNPACK) begin
            phase_eff = (phase_in > GROUP_LEN) ? '0 : phase_in;
        end else begin
            phase_eff = (phase_in >= GROUP_LEN) ? '0 : phase_in;
        end
    end

    // Unpacked pixels: held high byte joined with its pair from the current byte.
    always_comb begin
        logic [2:0] sh;
        for (int k = 0; k < 4; k++) begin
            sh = (i_cfg.bit_order == ORDER_MIPI) ? 3'(2 * k) : 3'(6 - 2 * k);
            unpack_pix[k] = {r_held[k], 2'(i_item.in_value[BYTE_W-1:0] >> sh) & LOW_MASK};
        end
    end

    // Low-bits byte: held pairs of the first three pixels and the current one.
    always_comb begin
        logic [2:0] sh;
        logic [1:0] pair;
        packed_lows = '0;
        for (int k = 0; k < 4; k++) begin
            sh   = (i_cfg.bit_order == ORDER_MIPI) ? 3'(2 * k) : 3'(6 - 2 * k);
            pair = (k == 3) ? i_item.in_value[1:0] : (r_held[k][1:0] & LOW_MASK);
            packed_lows = packed_lows | ((BYTE_W'(pair) << sh) & BYTE_MASK);
        end
    end

    // Per-item decision: hold, emit pixels, or emit one or two bytes.
    always_comb begin
        n_phase   = r_phase;
        o_push    = 1'b0;
        hold_we   = 1'b0;
        hold_data = i_item.in_value[BYTE_W-1:0];
        o_job     = '0;
        if (i_accept) begin
            if (i_cfg.direction == DIR_UNPACK) begin
                if (phase_eff < GROUP_LEN) begin
                    hold_we = 1'b1;
                    n_phase = phase_eff + 1'b1;
                end else begin
                    o_push         = 1'b1;
                    o_job.last_idx = 2'd3;
                    o_job.value    = unpack_pix;
                    n_phase        = '0;
                end
            end else begin
                hold_we        = 1'b1;
                hold_data      = {{(BYTE_W-2){1'b0}}, i_item.in_value[1:0]};
                o_push         = 1'b1;
                o_job.value[0] = {2'b00, i_item.in_value[VALUE_W-1:2]};
                if (phase_eff == GROUP_LEN - 1'b1) begin
                    o_job.last_idx = 2'd1;
                    o_job.value[1] = {2'b00, packed_lows};
                    n_phase        = '0;
                end else begin
                    o_job.last_idx = 2'd0;
                    n_phase        = phase_eff + 1'b1;
                end
            end
        end
    end

    // Group phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Held group values need no reset.
    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            r_held[phase_eff[1:0]] <= hold_data;
        end
    end

    `ASSERT_IMP(a_phase_range, 1'b1, r_phase <= GROUP_LEN)

endmodule

// ===== hw/rtl/rpp_queue.sv =====
// Short job queue between the front end and the result sequencer.
`include "raw10_pixel_pack_unpack_assert.svh"

module rpp_queue import rpp_pkg::*; #(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_job,
    input  logic i_rd,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(Depth);
    localparam int CNT_W = $clog2(Depth + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Depth - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Depth);

    t_job             r_mem [Depth];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `ASSERT_IMP(a_no_write_when_full, r_count == CNT_FULL, !i_wr)
    `ASSERT_IMP(a_no_read_when_empty, r_count == '0, !i_rd)

endmodule

// ===== hw/rtl/rpp_back.sv =====
// Back end: walks each queued job and delivers its results one per cycle while the result side keeps popping.
`include "raw10_pixel_pack_unpack_assert.svh"

module rpp_back import rpp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  logic      i_q_empty,
    output logic      o_q_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic       r_valid;
    logic       n_valid;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    t_out_item  r_item;
    logic       load;
    logic       is_last;

    // Refill the output register when it is free or being taken this cycle.
    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign is_last = (r_idx == i_head.last_idx);
    assign o_q_rd  = load && is_last;
    assign o_empty = !r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? '0 : r_idx + 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.out_value   <= i_head.value[r_idx];
            r_item.last_of_run <= is_last;
        end
    end

    `ASSERT_NXT(a_idx_wraps_after_job, o_q_rd, r_idx == '0)

endmodule

// ===== hw/rtl/raw10_pixel_pack_unpack.sv =====
// RAW10 pack/unpack top level: configuration registers and the front/queue/back pipeline.
//
// Converts a stream of packed RAW10 bytes into 10-bit pixels (direction 0) or
// 10-bit pixels into packed bytes (direction 1); bit_order selects whether the
// first pixel's low bits sit at the top (plain) or bottom (MIPI) of the
// low-bits byte, and frame_start restarts the group. The input side takes one
// item per clock while the job queue (QueueDepth entries) has room; the output
// side delivers at most one result per clock from a registered output stage,
// so the result port sets the sustained rate: unpacking returns four pixels
// per five bytes, packing returns five bytes per four pixels, and a full queue
// raises full until the result side drains it. An item's results are written
// into the job queue and then loaded into the output register. In unpacking, a
// partial trailing group produces nothing; in packing, it yields only its high
// bytes and no low-bits byte. Configuration must only be written while the block is idle.
module raw10_pixel_pack_unpack import rpp_pkg::*; #(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input queue side
    input  logic              push,
    output logic              full,
    input  t_in_item          i_in_data,
    // Result queue side
    output logic              empty,
    input  logic              pop,
    output t_out_item         o_out_data,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic cfg_wr;
    logic reg_idx;
    logic accept;
    logic job_push;
    t_job job;
    t_job head;
    logic q_full;
    logic q_empty;
    logic q_rd;

    // Configuration register writes and reads.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_DIRECTION: n_cfg.direction = t_direction'(pwdata[0]);
                REG_BIT_ORDER: n_cfg.bit_order = t_bit_order'(pwdata[0]);
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DIRECTION: prdata = {{(DATA_W-1){1'b0}}, r_cfg.direction};
            REG_BIT_ORDER: prdata = {{(DATA_W-1){1'b0}}, r_cfg.bit_order};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{direction: DIR_UNPACK, bit_order: ORDER_PLAIN};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // An input transfer happens whenever the job queue has room.
    assign full   = q_full;
    assign accept = push && !q_full;

    rpp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (job_push),
        .o_job    (job)
    );

    rpp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_job   (job),
        .i_rd    (q_rd),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rpp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_data)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RAW10 pack/unpack block with a built-in conversion predictor.
module tb;
    import rpp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 60;
    localparam int HOLD_CYCLES  = 120;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    t_in_item          i_in_data;
    logic              empty;
    logic              pop;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor copy of the block's configuration and group state.
    t_direction        cur_dir   = DIR_UNPACK;
    t_bit_order        cur_order = ORDER_PLAIN;
    logic [PHASE_W-1:0] grp_phase = '0;
    logic [BYTE_W-1:0] held [4];

    t_out_item         expected_stream [$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  mode_writes     = 0;
    int  cycle_count     = 0;
    int  hold_off_req    = 0;
    bit  steady          = 1'b0;

    raw10_pixel_pack_unpack u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_data  (i_in_data),
        .empty      (empty),
        .pop        (pop),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("[raw10_pixel_pack_unpack] ERROR");
            $finish;
        end
    end

    // Mostly no gap, some short gaps and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Bit position of the low pair of pixel k inside the low-bits byte.
    function automatic int low_pair_pos(int k);
        return (cur_order == ORDER_MIPI) ? 2 * k : 6 - 2 * k;
    endfunction

    // Works out the results that one accepted element causes.
    function automatic void predict_conversion(t_in_item it);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] lows;
        t_out_item         r;
        if (it.frame_start) begin
            grp_phase = '0;
        end
        if (cur_dir == DIR_UNPACK) begin
            // Bits 9:8 of the input are not part of a packed byte.
            b = it.in_value[BYTE_W-1:0];
            if (grp_phase > GROUP_LEN) begin
                grp_phase = '0;
            end
            if (grp_phase < GROUP_LEN) begin
                held[grp_phase[1:0]] = b;
                grp_phase++;
            end else begin
                for (int k = 0; k < 4; k++) begin
                    r.out_value   = {held[k], 2'((b >> low_pair_pos(k)) & LOW_MASK)};
                    r.last_of_run = (k == 3);
                    expected_stream.push_back(r);
                end
                grp_phase = '0;
            end
        end else begin
            if (grp_phase >= GROUP_LEN) begin
                grp_phase = '0;
            end
            r.out_value = {2'b00, it.in_value[VALUE_W-1:2]};
            held[grp_phase[1:0]] = {6'd0, it.in_value[1:0]};
            grp_phase++;
            if (grp_phase < GROUP_LEN) begin
                r.last_of_run = 1'b1;
                expected_stream.push_back(r);
            end else begin
                r.last_of_run = 1'b0;
                expected_stream.push_back(r);
                lows = '0;
                for (int k = 0; k < 4; k++) begin
                    lows = lows | (8'(held[k][1:0] & LOW_MASK) << low_pair_pos(k));
                end
                r.out_value   = {2'b00, lows & BYTE_MASK};
                r.last_of_run = 1'b1;
                expected_stream.push_back(r);
                grp_phase = '0;
            end
        end
    endfunction

    // Compares every result transfer with the oldest expected result.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (expected_stream.size() == 0) begin
                $display("%0t: unexpected result, expected none, got value %h last %b",
                         $time, o_out_data.out_value, o_out_data.last_of_run);
                error_count++;
            end else begin
                want = expected_stream.pop_front();
                results_checked++;
                if (o_out_data.out_value !== want.out_value) begin
                    $display("%0t: out_value mismatch, expected %h, got %h",
                             $time, want.out_value, o_out_data.out_value);
                    error_count++;
                end
                if (o_out_data.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run mismatch, expected %b, got %b",
                             $time, want.last_of_run, o_out_data.last_of_run);
                    error_count++;
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_drain
        int stall;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_off_req > 0) begin
                stall = hold_off_req;
                hold_off_req = 0;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Offers one element and waits for its transfer; push stays high afterward.
    task automatic send_item(input logic [VALUE_W-1:0] value, input logic fs);
        t_in_item it;
        it.in_value    = value;
        it.frame_start = fs;
        i_in_data <= it;
        push      <= 1'b1;
        do @(posedge i_clk); while (full);
        predict_conversion(it);
        items_sent++;
    endtask

    task automatic idle_tx(input int cycles);
        if (cycles > 0) begin
            push <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Waits until every expected result has come back and the block has gone quiet.
    task automatic settle();
        push <= 1'b0;
        while (expected_stream.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~32'd1) | DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DIRECTION) begin
            cur_dir = t_direction'(value);
        end else begin
            cur_order = t_bit_order'(value);
        end
    endtask

    task automatic set_mode(input t_direction dir, input t_bit_order order);
        settle();
        write_reg(REG_DIRECTION, dir);
        write_reg(REG_BIT_ORDER, order);
        mode_writes++;
    endtask

    // One well-formed group with random content and random gaps.
    task automatic send_group(input bit fs_first);
        int n;
        n = int'(GROUP_LEN) + ((cur_dir == DIR_UNPACK) ? 1 : 0);
        for (int i = 0; i < n; i++) begin
            send_item(10'($urandom_range(0, 1023)), fs_first && i == 0);
            idle_tx(pick_gap());
        end
    endtask

    // Unpacking in both bit orders, with the unused upper input bits set in the plain-order group.
    task automatic test_unpack_directed();
        set_mode(DIR_UNPACK, ORDER_PLAIN);
        send_item(10'h3FF, 1'b1);
        send_item(10'h300, 1'b0);
        send_item(10'h2AA, 1'b0);
        send_item(10'h155, 1'b0);
        send_item(10'h3E4, 1'b0);
        set_mode(DIR_UNPACK, ORDER_MIPI);
        send_item(10'h000, 1'b1);
        send_item(10'h0FF, 1'b0);
        send_item(10'h080, 1'b0);
        send_item(10'h001, 1'b0);
        send_item(10'h01B, 1'b0);
    endtask

    // Packing in both bit orders; a frame restart drops a stray pixel's low bits after its high byte is sent.
    task automatic test_pack_directed();
        set_mode(DIR_PACK, ORDER_PLAIN);
        send_item(10'h3FF, 1'b1);
        send_item(10'h000, 1'b0);
        send_item(10'h2AA, 1'b0);
        send_item(10'h155, 1'b0);
        set_mode(DIR_PACK, ORDER_MIPI);
        send_item(10'h201, 1'b0);
        send_item(10'h001, 1'b1);
        send_item(10'h002, 1'b0);
        send_item(10'h3FE, 1'b0);
        send_item(10'h203, 1'b0);
    endtask

    // Four held bytes leave the phase at the end of a group; packing then restarts it.
    task automatic test_direction_switch();
        set_mode(DIR_UNPACK, ORDER_PLAIN);
        send_item(10'h0C3, 1'b1);
        send_item(10'h13C, 1'b0);
        send_item(10'h255, 1'b0);
        send_item(10'h3AA, 1'b0);
        set_mode(DIR_PACK, ORDER_PLAIN);
        send_item(10'h3FD, 1'b0);
        send_item(10'h002, 1'b0);
        send_item(10'h1C3, 1'b0);
        send_item(10'h27E, 1'b0);
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills up.
    task automatic test_full_stall();
        set_mode(DIR_PACK, ORDER_MIPI);
        steady = 1'b1;
        hold_off_req = HOLD_CYCLES;
        repeat (5) send_group(1'b0);
        steady = 1'b0;
        // Sender pauses until every result is back, then resumes.
        settle();
        repeat (3) send_group(1'b1);
    endtask

    // Random modes, mostly whole groups, some stray elements and restarts.
    task automatic test_random_stream();
        int start;
        start = items_sent;
        for (int round = 0; items_sent - start < RANDOM_ITEMS; round++) begin
            steady = (round % 4 == 3);
            set_mode(t_direction'($urandom_range(0, 1)), t_bit_order'($urandom_range(0, 1)));
            repeat ($urandom_range(3, 6)) begin
                if ($urandom_range(0, 99) < 80) begin
                    send_group($urandom_range(0, 2) == 0);
                end else begin
                    send_item(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
                    idle_tx(pick_gap());
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_in_data <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unpack_directed();
        test_pack_directed();
        test_direction_switch();
        test_full_stall();
        test_random_stream();
        settle();

        $display("Sent %0d elements and checked %0d results across %0d mode settings,",
                 items_sent, results_checked, mode_writes);
        $display("covering both directions, both bit orders, restarts and a full stall.");
        if (error_count == 0) begin
            $display("[raw10_pixel_pack_unpack] OK");
        end else begin
            $display("[raw10_pixel_pack_unpack] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_front.sv
hw/rtl/rpp_queue.sv
hw/rtl/rpp_back.sv
hw/rtl/raw10_pixel_pack_unpack.sv
test/tb.sv
